@@ src/dtwl_pkg.sv @@
// ----------------------------------------------------------------------------
// dtwl_pkg
// Types, constants and helper functions shared by the tuning word loader.
// ----------------------------------------------------------------------------
package dtwl_pkg;

   localparam int unsigned FREQ_W  = 32;
   localparam int unsigned PHASE_W = 16;
   localparam int unsigned CLK_W   = 32;
   localparam int unsigned TW_W    = 32;
   localparam int unsigned CTRL_W  = 8;
   localparam int unsigned LOAD_W  = TW_W + CTRL_W;
   localparam int unsigned CODE_W  = 5;

   localparam logic [CLK_W-1:0] REF_CLOCK_RESET = CLK_W'(180000000);

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // The dividend is {freq, 32 zeros}; two quotient bits are resolved per cycle.
   localparam int unsigned DIV_BITS_PER_CYCLE = 2;
   localparam int unsigned DIV_CYCLES = (FREQ_W + TW_W) / DIV_BITS_PER_CYCLE;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

   // Phase reduction: q = floor(deg / 360) as (deg * DEG_RECIP) >> DEG_SHIFT,
   // then code = floor(p * 32 / 360) as (p * CODE_RECIP) >> CODE_SHIFT.
   localparam int unsigned DEG_FULL   = 360;
   localparam int unsigned DEG_RECIP  = 46604;
   localparam int unsigned DEG_SHIFT  = 24;
   localparam int unsigned DEG_Q_W    = 8;
   localparam int unsigned PMOD_W     = 9;
   localparam int unsigned CODE_RECIP = 5828;
   localparam int unsigned CODE_SHIFT = 16;
   localparam int unsigned CODE_PROD_W = 22;

   // Low control bits: multiplier enable set, reserved and power-down clear.
   localparam logic [2:0] CTRL_LOW_BITS = 3'b001;

   typedef logic [LOAD_W-1:0] load_word_type;

   typedef struct packed {
      logic          valid;
      load_word_type word;
   } load_item_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIVIDE,
      FE_PUSH
   } fe_state_type;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [CLK_W:0] div_step(input logic [CLK_W-1:0] rem,
                                               input logic             din,
                                               input logic [CLK_W-1:0] divisor);
      logic [CLK_W:0] trial;
      logic [CLK_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         return {1'b1, diff[CLK_W-1:0]};
      end else begin
         return {1'b0, trial[CLK_W-1:0]};
      end
   endfunction

endpackage

@@ src/dtwl_if.sv @@
// ----------------------------------------------------------------------------
// dtwl interfaces
// Valid/ready channels for requests, serial responses and the clock register.
// ----------------------------------------------------------------------------
interface dtwl_req_if import dtwl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FREQ_W-1:0]  freq_hz;
   logic [PHASE_W-1:0] phase_degrees;

   modport source (output valid, output freq_hz, output phase_degrees, input ready);
   modport sink   (input valid, input freq_hz, input phase_degrees, output ready);
endinterface

interface dtwl_rsp_if import dtwl_pkg::*; ();
   logic valid;
   logic ready;
   logic serial_bit;
   logic last_bit;

   modport source (output valid, output serial_bit, output last_bit, input ready);
   modport sink   (input valid, input serial_bit, input last_bit, output ready);
endinterface

interface dtwl_csr_if import dtwl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CLK_W-1:0] ref_clock_hz;

   modport source (output valid, output ref_clock_hz, input ready);
   modport sink   (input valid, input ref_clock_hz, output ready);
endinterface

@@ src/dds_tuning_word_serial_loader.sv @@
// ----------------------------------------------------------------------------
// dds_tuning_word_serial_loader
// Converts frequency and phase requests into serial 40-bit DDS load words.
// ----------------------------------------------------------------------------
// Channels: a request carries freq_hz and phase_degrees; each request yields
// forty responses, one serial_bit each, LSB first: tuning word
// floor(freq_hz * 2^32 / ref_clock_hz) low 32 bits, then the control byte
// {phase code, 3'b001}. last_bit marks the fortieth bit so that the update
// strobe can follow. The csr channel writes ref_clock_hz and is always ready.
// The front resolves two quotient bits per cycle; the serializer sends one
// response per cycle while the receiver is ready, and it is the serializer
// that sets the sustained request rate. A holding register takes the next
// request while the previous one divides, and a short queue lets the
// divider run ahead of a stalled receiver. When the receiver stalls, the
// current bit holds and the queue fills, then requests back up. Reset
// empties the pipeline and the queue and restores ref_clock_hz to 180 MHz.
// ----------------------------------------------------------------------------
module dds_tuning_word_serial_loader import dtwl_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dtwl_csr_if.sink   csr_chan,
   dtwl_req_if.sink   req_chan,
   dtwl_rsp_if.source rsp_chan
);

   logic [CLK_W-1:0] ref_clock_ff, ref_clock_in;
   load_item_type    front_push;
   logic             front_push_ready;
   load_item_type    queue_head;
   logic             queue_pop;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      ref_clock_in = ref_clock_ff;
      if (csr_chan.valid) ref_clock_in = csr_chan.ref_clock_hz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= REF_CLOCK_RESET;
      end else begin
         ref_clock_ff <= ref_clock_in;
      end
   end

   dtwl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .ref_clock_hz (ref_clock_ff),
      .req          (req_chan),
      .push         (front_push),
      .push_ready   (front_push_ready)
   );

   dtwl_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (front_push),
      .wr_ready (front_push_ready),
      .rd       (queue_head),
      .rd_ready (queue_pop)
   );

   dtwl_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .queue     (queue_head),
      .queue_pop (queue_pop),
      .rsp       (rsp_chan)
   );

endmodule

@@ src/dtwl_front.sv @@
// ----------------------------------------------------------------------------
// dtwl_front
// Accepts requests, divides out the tuning word and builds the control byte.
// ----------------------------------------------------------------------------
module dtwl_front import dtwl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CLK_W-1:0] ref_clock_hz,
   dtwl_req_if.sink         req,
   output load_item_type    push,
   input  logic             push_ready
);

   fe_state_type             state_ff, state_in;
   logic                     hold_valid_ff, hold_valid_in;
   logic [FREQ_W-1:0]        hold_freq_ff, hold_freq_in;
   logic [PHASE_W-1:0]       hold_phase_ff, hold_phase_in;
   logic [CLK_W-1:0]         rem_ff, rem_in;
   logic [FREQ_W-1:0]        num_ff, num_in;
   logic [TW_W-1:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PHASE_W-1:0]       deg_ff, deg_in;
   logic [DEG_Q_W-1:0]       degq_ff, degq_in;
   logic [PMOD_W-1:0]        pmod_ff, pmod_in;
   logic [CODE_W-1:0]        code_ff, code_in;

   logic                     accept;
   logic                     start;
   logic                     div_last;
   logic [CLK_W:0]           step_hi;
   logic [CLK_W:0]           step_lo;
   logic [31:0]              degq_prod;
   logic [PHASE_W-1:0]       deg_multiple;
   logic [CODE_PROD_W-1:0]   code_prod;

   assign req.ready = !hold_valid_ff;
   assign accept    = req.valid && !hold_valid_ff;
   assign div_last  = (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));
   assign start     = hold_valid_ff &&
                      ((state_ff == FE_IDLE) || ((state_ff == FE_PUSH) && push_ready));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_IDLE: begin
            if (start) state_in = FE_DIVIDE;
         end
         FE_DIVIDE: begin
            if (div_last) state_in = FE_PUSH;
         end
         FE_PUSH: begin
            if (start) begin
               state_in = FE_DIVIDE;
            end else if (push_ready) begin
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      push.valid = 1'b0;
      push.word  = {code_ff, CTRL_LOW_BITS, quo_ff};
      case (state_ff)
         FE_IDLE:   push.valid = 1'b0;
         FE_DIVIDE: push.valid = 1'b0;
         FE_PUSH:   push.valid = 1'b1;
         default:   push.valid = 1'b0;
      endcase
   end

   // Request holding register
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_freq_in  = hold_freq_ff;
      hold_phase_in = hold_phase_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_freq_in  = req.freq_hz;
         hold_phase_in = req.phase_degrees;
      end else if (start) begin
         hold_valid_in = 1'b0;
      end
   end

   // Two restoring steps per cycle over the dividend {freq, zeros}.
   assign step_hi = div_step(rem_ff, num_ff[FREQ_W-1], ref_clock_hz);
   assign step_lo = div_step(step_hi[CLK_W-1:0], num_ff[FREQ_W-2], ref_clock_hz);

   // Phase reduction runs in the first cycles of the division, one product each.
   assign degq_prod    = 32'(deg_ff) * 32'(DEG_RECIP);
   assign deg_multiple = PHASE_W'(degq_ff * PHASE_W'(DEG_FULL));
   assign code_prod    = CODE_PROD_W'(pmod_ff) * CODE_PROD_W'(CODE_RECIP);

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      deg_in  = deg_ff;
      degq_in = degq_ff;
      pmod_in = pmod_ff;
      code_in = code_ff;
      if (start) begin
         rem_in = '0;
         num_in = hold_freq_ff;
         cnt_in = '0;
         deg_in = hold_phase_ff;
      end else if (state_ff == FE_DIVIDE) begin
         rem_in = step_lo[CLK_W-1:0];
         num_in = {num_ff[FREQ_W-3:0], 2'b00};
         quo_in = {quo_ff[TW_W-3:0], step_hi[CLK_W], step_lo[CLK_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(0)) degq_in = degq_prod[DEG_SHIFT +: DEG_Q_W];
         if (cnt_ff == DIV_CNT_W'(1)) pmod_in = PMOD_W'(deg_ff - deg_multiple);
         if (cnt_ff == DIV_CNT_W'(2)) code_in = code_prod[CODE_SHIFT +: CODE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FE_IDLE;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_freq_ff  <= hold_freq_in;
      hold_phase_ff <= hold_phase_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      deg_ff        <= deg_in;
      degq_ff       <= degq_in;
      pmod_ff       <= pmod_in;
      code_ff       <= code_in;
   end

endmodule

@@ src/dtwl_fifo.sv @@
// ----------------------------------------------------------------------------
// dtwl_fifo
// Short queue of load words between the front and the serializer.
// ----------------------------------------------------------------------------
module dtwl_fifo import dtwl_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  load_item_type wr,
   output logic          wr_ready,
   output load_item_type rd,
   input  logic          rd_ready
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   load_word_type  mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_wr;
   logic           do_rd;

   assign wr_ready = (count_ff != CW'(DEPTH));
   assign rd.valid = (count_ff != '0);
   assign rd.word  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr.valid && wr_ready;
   assign do_rd    = rd.valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr.word;
   end

endmodule

@@ src/dtwl_serializer.sv @@
// ----------------------------------------------------------------------------
// dtwl_serializer
// Shifts each 40-bit load word out one bit per response, LSB first.
// ----------------------------------------------------------------------------
module dtwl_serializer import dtwl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  load_item_type queue,
   output logic          queue_pop,
   dtwl_rsp_if.source    rsp
);

   localparam int unsigned BIT_CNT_W = $clog2(LOAD_W);

   logic                 busy_ff, busy_in;
   load_word_type        shift_ff, shift_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 fire;
   logic                 last;
   logic                 load;

   assign last = (bit_cnt_ff == BIT_CNT_W'(LOAD_W - 1));
   assign fire = busy_ff && rsp.ready;
   // The next word is taken in the same cycle the last bit of the previous one leaves.
   assign load = queue.valid && (!busy_ff || (fire && last));

   assign queue_pop      = load;
   assign rsp.valid      = busy_ff;
   assign rsp.serial_bit = shift_ff[0];
   assign rsp.last_bit   = last;

   always_comb begin
      busy_in    = busy_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      if (load) begin
         busy_in    = 1'b1;
         shift_in   = queue.word;
         bit_cnt_in = '0;
      end else if (fire) begin
         shift_in   = {1'b0, shift_ff[LOAD_W-1:1]};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

@@ src/dtwl_checker.sv @@
// ----------------------------------------------------------------------------
// dtwl_checker
// Port-level checks on the serial response stream of the loader.
// ----------------------------------------------------------------------------
module dtwl_checker import dtwl_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic serial_bit,
   input logic last_bit
);

   localparam int unsigned IDX_W = $clog2(LOAD_W);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             fire;

   assign fire = rsp_valid && rsp_ready;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = (idx_ff == IDX_W'(LOAD_W - 1)) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(serial_bit) && $stable(last_bit))
      else $error("response changed while stalled");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_bit == (idx_ff == IDX_W'(LOAD_W - 1))))
      else $error("last_bit not on the fortieth bit");

   a_mult_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (idx_ff == IDX_W'(TW_W)) |-> serial_bit)
      else $error("multiplier enable bit not set");

   a_ctrl_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((idx_ff == IDX_W'(TW_W + 1)) || (idx_ff == IDX_W'(TW_W + 2)))
      |-> !serial_bit)
      else $error("reserved or power-down bit set");

endmodule

bind dds_tuning_word_serial_loader dtwl_checker u_dtwl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .serial_bit (rsp_chan.serial_bit),
   .last_bit   (rsp_chan.last_bit)
);
